/* design/prha_pkg.sv */
// shared constants, codes and types for the power rail hold arbiter
`default_nettype none

package prha_pkg;

    localparam int NUM_CLIENTS = 8;
    localparam int HOLD_BITS   = 8;
    localparam int CLIENT_W    = 3;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int SUM_W       = 11;

    localparam int S_DATA_W = ((MODE_W + CLIENT_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STATUS_W + 3 + 3 * SUM_W + 7) / 8) * 8;

    localparam logic [MODE_W-1:0] MODE_HOLD_A_ON  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REL_A_ON   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HOLD_A_OFF = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REL_A_OFF  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOLD_B_ON  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REL_B_ON   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_HOLD = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    localparam logic [1:0] KIND_A_ON  = 2'd0;
    localparam logic [1:0] KIND_A_OFF = 2'd1;
    localparam logic [1:0] KIND_B_ON  = 2'd2;

    localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};
    localparam logic [SUM_W-1:0]     SUM_MAX  = {SUM_W{1'b1}};

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 cnt_we;
        logic [1:0]           kind;
        logic [HOLD_BITS-1:0] cnt;
        logic [SUM_W-1:0]     a_on_sum;
        logic [SUM_W-1:0]     a_off_sum;
        logic [SUM_W-1:0]     b_on_sum;
        logic                 a_en;
        logic                 b_en;
        logic                 switched;
    } t_upd;

endpackage

`default_nettype wire

/* design/prha_update.sv */
// next-state and result logic for one hold request or release
`default_nettype none

module prha_update (
    input  wire logic [prha_pkg::MODE_W-1:0]    i_mode,
    input  wire logic                           i_client_ok,
    input  wire logic [prha_pkg::HOLD_BITS-1:0] i_a_on_cnt,
    input  wire logic [prha_pkg::HOLD_BITS-1:0] i_a_off_cnt,
    input  wire logic [prha_pkg::HOLD_BITS-1:0] i_b_on_cnt,
    input  wire logic [prha_pkg::SUM_W-1:0]     i_a_on_sum,
    input  wire logic [prha_pkg::SUM_W-1:0]     i_a_off_sum,
    input  wire logic [prha_pkg::SUM_W-1:0]     i_b_on_sum,
    input  wire logic                           i_a_en,
    input  wire logic                           i_b_en,
    output prha_pkg::t_upd                      o_upd
);

    logic                           mode_ok;
    logic                           is_hold;
    logic                           opposed;
    logic [1:0]                     kind;
    logic [prha_pkg::HOLD_BITS-1:0] sel_cnt;
    logic [prha_pkg::SUM_W-1:0]     sel_sum;
    logic [prha_pkg::SUM_W-1:0]     new_sum;

    always_comb begin
        mode_ok = 1'b1;
        is_hold = 1'b0;
        opposed = 1'b0;
        kind    = prha_pkg::KIND_A_ON;
        case (i_mode)
            prha_pkg::MODE_HOLD_A_ON: begin
                is_hold = 1'b1;
                opposed = (i_a_off_sum != '0);
            end
            prha_pkg::MODE_REL_A_ON: begin
                kind = prha_pkg::KIND_A_ON;
            end
            prha_pkg::MODE_HOLD_A_OFF: begin
                is_hold = 1'b1;
                kind    = prha_pkg::KIND_A_OFF;
                opposed = (i_a_on_sum != '0);
            end
            prha_pkg::MODE_REL_A_OFF: begin
                kind = prha_pkg::KIND_A_OFF;
            end
            prha_pkg::MODE_HOLD_B_ON: begin
                is_hold = 1'b1;
                kind    = prha_pkg::KIND_B_ON;
            end
            prha_pkg::MODE_REL_B_ON: begin
                kind = prha_pkg::KIND_B_ON;
            end
            default: begin
                mode_ok = 1'b0;
            end
        endcase

        case (kind)
            prha_pkg::KIND_A_OFF: begin
                sel_cnt = i_a_off_cnt;
                sel_sum = i_a_off_sum;
            end
            prha_pkg::KIND_B_ON: begin
                sel_cnt = i_b_on_cnt;
                sel_sum = i_b_on_sum;
            end
            default: begin
                sel_cnt = i_a_on_cnt;
                sel_sum = i_a_on_sum;
            end
        endcase

        o_upd.status = prha_pkg::ST_DONE;
        o_upd.cnt_we = 1'b0;
        o_upd.kind   = kind;
        o_upd.cnt    = sel_cnt;
        new_sum      = sel_sum;

        if (i_client_ok && mode_ok) begin
            if (is_hold) begin
                // opposing holds win over a full counter
                if (opposed) begin
                    o_upd.status = prha_pkg::ST_REJECT;
                end else if (sel_cnt == prha_pkg::HOLD_MAX || sel_sum == prha_pkg::SUM_MAX) begin
                    o_upd.status = prha_pkg::ST_FULL;
                end else begin
                    o_upd.cnt_we = 1'b1;
                    o_upd.cnt    = sel_cnt + 1'b1;
                    new_sum      = sel_sum + 1'b1;
                end
            end else if (sel_cnt == '0) begin
                o_upd.status = prha_pkg::ST_NO_HOLD;
            end else begin
                o_upd.cnt_we = 1'b1;
                o_upd.cnt    = sel_cnt - 1'b1;
                new_sum      = (sel_sum != '0) ? sel_sum - 1'b1 : sel_sum;
            end
        end

        o_upd.a_on_sum  = (kind == prha_pkg::KIND_A_ON)  ? new_sum : i_a_on_sum;
        o_upd.a_off_sum = (kind == prha_pkg::KIND_A_OFF) ? new_sum : i_a_off_sum;
        o_upd.b_on_sum  = (kind == prha_pkg::KIND_B_ON)  ? new_sum : i_b_on_sum;

        // any off hold forces rail a low
        o_upd.a_en     = (o_upd.a_off_sum == '0) && (o_upd.a_on_sum != '0);
        o_upd.b_en     = (o_upd.b_on_sum != '0);
        o_upd.switched = (o_upd.a_en != i_a_en) || (o_upd.b_en != i_b_en);
    end

endmodule

`default_nettype wire

/* design/power_rail_hold_arbiter.sv */
// top level of the power rail hold arbiter
`default_nettype none

// Each input transaction is one hold or release (mode, client) and gives exactly
// one result transaction: a status code, the rail A and rail B enables, a flag
// when either enable changed, and the three hold totals as they stand after the
// request. A transaction is registered on entry and resolved, once the result
// register is free, by one read-modify-write of the per-client counters and totals
// into the result register, so the block takes one transaction per cycle while the
// result side does not stall. Per-client and total counters are cleared by reset;
// no sweep is needed afterwards.
module power_rail_hold_arbiter (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // mode[2:0], client[5:3], zero pad
    input  wire logic [prha_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // status[1:0], rail_a_enable[2], rail_b_enable[3], rail_switched[4],
    // on_hold_total[15:5], off_hold_total[26:16], b_hold_total[37:27], zero pad
    output logic [prha_pkg::M_DATA_W-1:0]        o_m_tdata
);

    localparam int OUT_USED_W = prha_pkg::STATUS_W + 3 + 3 * prha_pkg::SUM_W;

    logic [prha_pkg::HOLD_BITS-1:0] r_a_on_cnt  [prha_pkg::NUM_CLIENTS];
    logic [prha_pkg::HOLD_BITS-1:0] r_a_off_cnt [prha_pkg::NUM_CLIENTS];
    logic [prha_pkg::HOLD_BITS-1:0] r_b_on_cnt  [prha_pkg::NUM_CLIENTS];
    logic [prha_pkg::SUM_W-1:0]     r_a_on_sum;
    logic [prha_pkg::SUM_W-1:0]     r_a_off_sum;
    logic [prha_pkg::SUM_W-1:0]     r_b_on_sum;
    logic                           r_a_en;
    logic                           r_b_en;

    logic                           r_in_vld;
    logic [prha_pkg::MODE_W-1:0]    r_mode;
    logic [prha_pkg::CLIENT_W-1:0]  r_client;

    logic                           r_out_vld;
    logic [OUT_USED_W-1:0]          r_out_data;

    logic                           w_adv;
    logic                           w_upd;
    logic                           w_client_ok;
    prha_pkg::t_upd                 w_res;

    // result register frees up when empty or being taken
    assign w_adv       = !r_out_vld || i_m_tready;
    assign w_upd       = r_in_vld && w_adv;
    assign o_s_tready  = !r_in_vld || w_adv;
    assign w_client_ok = ({{(32 - prha_pkg::CLIENT_W){1'b0}}, r_client}
                          < 32'(prha_pkg::NUM_CLIENTS));

    prha_update u_update (
        .i_mode      (r_mode),
        .i_client_ok (w_client_ok),
        .i_a_on_cnt  (r_a_on_cnt[r_client]),
        .i_a_off_cnt (r_a_off_cnt[r_client]),
        .i_b_on_cnt  (r_b_on_cnt[r_client]),
        .i_a_on_sum  (r_a_on_sum),
        .i_a_off_sum (r_a_off_sum),
        .i_b_on_sum  (r_b_on_sum),
        .i_a_en      (r_a_en),
        .i_b_en      (r_b_en),
        .o_upd       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_mode   <= i_s_tdata[prha_pkg::MODE_W-1:0];
            r_client <= i_s_tdata[prha_pkg::MODE_W +: prha_pkg::CLIENT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < prha_pkg::NUM_CLIENTS; i++) begin
                r_a_on_cnt[i]  <= '0;
                r_a_off_cnt[i] <= '0;
                r_b_on_cnt[i]  <= '0;
            end
            r_a_on_sum  <= '0;
            r_a_off_sum <= '0;
            r_b_on_sum  <= '0;
            r_a_en      <= 1'b0;
            r_b_en      <= 1'b0;
        end else if (w_upd) begin
            if (w_res.cnt_we) begin
                case (w_res.kind)
                    prha_pkg::KIND_A_ON:  r_a_on_cnt[r_client]  <= w_res.cnt;
                    prha_pkg::KIND_A_OFF: r_a_off_cnt[r_client] <= w_res.cnt;
                    prha_pkg::KIND_B_ON:  r_b_on_cnt[r_client]  <= w_res.cnt;
                    default: begin
                    end
                endcase
            end
            r_a_on_sum  <= w_res.a_on_sum;
            r_a_off_sum <= w_res.a_off_sum;
            r_b_on_sum  <= w_res.b_on_sum;
            r_a_en      <= w_res.a_en;
            r_b_en      <= w_res.b_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd) begin
            r_out_data <= {w_res.b_on_sum, w_res.a_off_sum, w_res.a_on_sum,
                           w_res.switched, w_res.b_en, w_res.a_en, w_res.status};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(prha_pkg::M_DATA_W - OUT_USED_W){1'b0}}, r_out_data};

`ifndef ASSERT_OFF
    a_no_opposing_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((r_a_on_sum != '0) && (r_a_off_sum != '0)))
        else $error("rail a on and off holds present together");

    a_rail_a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_en == ((r_a_on_sum != '0) && (r_a_off_sum == '0)))
        else $error("rail a enable disagrees with hold totals");

    a_rail_b_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_en == (r_b_on_sum != '0))
        else $error("rail b enable disagrees with hold total");

    a_totals_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_upd |=> ($stable(r_a_on_sum) && $stable(r_a_off_sum) && $stable(r_b_on_sum)))
        else $error("hold totals changed without a transaction");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd |=> r_out_vld)
        else $error("resolved transaction gave no result");
`endif

endmodule

`default_nettype wire

/* tb/prha_result_check.sv */
`timescale 1ns / 1ps
// result checker for the power rail hold arbiter: predicts each result and compares it
module prha_result_check
    import prha_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    input  wire logic                  i_s_tready,
    // mode[2:0], client[5:3], zero pad
    input  wire logic [S_DATA_W-1:0]   i_s_tdata,
    input  wire logic                  i_m_tvalid,
    input  wire logic                  i_m_tready,
    // status[1:0], rail_a_enable[2], rail_b_enable[3], rail_switched[4],
    // on_hold_total[15:5], off_hold_total[26:16], b_hold_total[37:27], zero pad
    input  wire logic [M_DATA_W-1:0]   i_m_tdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                rail_a;
        logic                rail_b;
        logic                switched;
        logic [SUM_W-1:0]    on_total;
        logic [SUM_W-1:0]    off_total;
        logic [SUM_W-1:0]    b_total;
    } t_hold_result;

    // per-client hold counts and totals, indexed by hold kind
    logic [HOLD_BITS-1:0] hold_cnt [3][NUM_CLIENTS];
    logic [SUM_W-1:0]     hold_sum [3];
    logic                 rail_a_on;
    logic                 rail_b_on;

    t_hold_result expected_results [$];
    int           fails = 0;

    function automatic logic [STATUS_W-1:0] take_hold(input logic [1:0] kind,
                                                      input logic [CLIENT_W-1:0] client);
        if (hold_cnt[kind][client] == HOLD_MAX || hold_sum[kind] == SUM_MAX)
            return ST_FULL;
        hold_cnt[kind][client] = hold_cnt[kind][client] + 1'b1;
        hold_sum[kind] = hold_sum[kind] + 1'b1;
        return ST_DONE;
    endfunction

    function automatic logic [STATUS_W-1:0] drop_hold(input logic [1:0] kind,
                                                      input logic [CLIENT_W-1:0] client);
        if (hold_cnt[kind][client] == '0)
            return ST_NO_HOLD;
        hold_cnt[kind][client] = hold_cnt[kind][client] - 1'b1;
        if (hold_sum[kind] != '0)
            hold_sum[kind] = hold_sum[kind] - 1'b1;
        return ST_DONE;
    endfunction

    function automatic t_hold_result arbitrate_hold(input logic [MODE_W-1:0] mode,
                                                    input logic [CLIENT_W-1:0] client);
        t_hold_result r;
        logic         a_next;
        logic         b_next;
        r = '0;
        r.status = ST_DONE;
        if (int'(client) < NUM_CLIENTS) begin
            case (mode)
                MODE_HOLD_A_ON: begin
                    if (hold_sum[KIND_A_OFF] != '0)
                        r.status = ST_REJECT;
                    else
                        r.status = take_hold(KIND_A_ON, client);
                end
                MODE_REL_A_ON:  r.status = drop_hold(KIND_A_ON, client);
                MODE_HOLD_A_OFF: begin
                    if (hold_sum[KIND_A_ON] != '0)
                        r.status = ST_REJECT;
                    else
                        r.status = take_hold(KIND_A_OFF, client);
                end
                MODE_REL_A_OFF: r.status = drop_hold(KIND_A_OFF, client);
                MODE_HOLD_B_ON: r.status = take_hold(KIND_B_ON, client);
                MODE_REL_B_ON:  r.status = drop_hold(KIND_B_ON, client);
                default: ;
            endcase
        end
        // any off hold wins over on holds for rail a
        a_next = (hold_sum[KIND_A_OFF] != '0) ? 1'b0 : (hold_sum[KIND_A_ON] != '0);
        b_next = (hold_sum[KIND_B_ON] != '0);
        r.switched  = (a_next != rail_a_on) || (b_next != rail_b_on);
        rail_a_on   = a_next;
        rail_b_on   = b_next;
        r.rail_a    = a_next;
        r.rail_b    = b_next;
        r.on_total  = hold_sum[KIND_A_ON];
        r.off_total = hold_sum[KIND_A_OFF];
        r.b_total   = hold_sum[KIND_B_ON];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hold_result exp_r;
        t_hold_result got_r;
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                hold_sum[k] = '0;
                for (int n = 0; n < NUM_CLIENTS; n++)
                    hold_cnt[k][n] = '0;
            end
            rail_a_on = 1'b0;
            rail_b_on = 1'b0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(arbitrate_hold(
                    i_s_tdata[MODE_W-1:0], i_s_tdata[MODE_W+CLIENT_W-1:MODE_W]));
            if (i_m_tvalid && i_m_tready) begin
                got_r.status    = i_m_tdata[1:0];
                got_r.rail_a    = i_m_tdata[2];
                got_r.rail_b    = i_m_tdata[3];
                got_r.switched  = i_m_tdata[4];
                got_r.on_total  = i_m_tdata[15:5];
                got_r.off_total = i_m_tdata[26:16];
                got_r.b_total   = i_m_tdata[37:27];
                if (expected_results.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: result transaction with nothing expected, data %h",
                                 $realtime, i_m_tdata);
                    fails++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got_r != exp_r) begin
                        if (fails < MAX_REPORTS)
                            $display({"%0t: mismatch (expected/actual) status %0d/%0d ",
                                      "rail_a %0b/%0b rail_b %0b/%0b switched %0b/%0b ",
                                      "on %0d/%0d off %0d/%0d b %0d/%0d"},
                                     $realtime, exp_r.status, got_r.status,
                                     exp_r.rail_a, got_r.rail_a, exp_r.rail_b, got_r.rail_b,
                                     exp_r.switched, got_r.switched,
                                     exp_r.on_total, got_r.on_total,
                                     exp_r.off_total, got_r.off_total,
                                     exp_r.b_total, got_r.b_total);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// testbench top for the power rail hold arbiter: stimulus, flow control and verdict
module tb;
    import prha_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int PHASE_ITEMS  = 300;
    localparam int HOLD_OFF_AT  = 1200;
    localparam int HOLD_OFF_LEN = 400;
    localparam int MIX_ITEMS    = 100;
    localparam int FILL_DEPTH   = 256;
    localparam int TAIL_CYCLES  = 8;
    localparam int LIMIT_CYCLES = 300000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    int                  fail_count;
    int                  pending;

    int   items_sent = 0;
    int   cycle_count = 0;
    logic hold_off_req = 1'b0;

    power_rail_hold_arbiter dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    prha_result_check result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // phases: none, sender idle, receiver stall, both
    function automatic int idle_phase();
        return (items_sent / PHASE_ITEMS) % 4;
    endfunction

    function automatic int sender_idle_pct();
        case (idle_phase())
            1:       return 63;
            3:       return 38;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case (idle_phase())
            2:       return 63;
            3:       return 38;
            default: return 0;
        endcase
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CLIENT_W-1:0] client);
        if (mode <= MODE_REL_B_ON) begin
            items_sent++;
            if (items_sent % PHASE_ITEMS == 0)
                wait_drained();
            if (items_sent == HOLD_OFF_AT)
                hold_off_req = 1'b1;
        end
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - MODE_W - CLIENT_W){1'b0}}, client, mode};
        do @(posedge clk); while (!s_tready);
    endtask

    // receiver: random stalls, plus one long hold-off so the block backs up
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_LEN - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_stall_pct());
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL power_rail_hold_arbiter");
        $finish;
    end

    initial begin
        int                  sel;
        int                  reps;
        int                  mix_end;
        logic [MODE_W-1:0]   hold_m;
        logic [MODE_W-1:0]   rel_m;
        logic [CLIENT_W-1:0] c;
        logic [CLIENT_W-1:0] c2;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: releases with no hold, rejects, rail switching, spare modes
        send_item(MODE_REL_A_ON, 3'd0);
        send_item(MODE_REL_A_OFF, 3'd7);
        send_item(MODE_REL_B_ON, 3'd3);
        send_item(MODE_HOLD_A_ON, 3'd0);
        send_item(MODE_HOLD_A_OFF, 3'd1);
        send_item(MODE_HOLD_A_ON, 3'd7);
        send_item(MODE_REL_A_ON, 3'd0);
        send_item(MODE_REL_A_ON, 3'd7);
        send_item(MODE_HOLD_A_OFF, 3'd5);
        send_item(MODE_HOLD_A_ON, 3'd2);
        send_item(MODE_HOLD_B_ON, 3'd5);
        send_item(MODE_SPARE_LO, 3'd5);
        send_item(MODE_SPARE_HI, 3'd2);
        send_item(MODE_REL_A_OFF, 3'd5);
        send_item(MODE_REL_B_ON, 3'd5);
        send_item(MODE_HOLD_A_ON, 3'd6);
        send_item(MODE_HOLD_B_ON, 3'd6);
        send_item(MODE_REL_A_ON, 3'd6);
        send_item(MODE_REL_B_ON, 3'd6);

        // saturate a rail a counter and a rail b counter (clients picked at random, maybe two)
        // from a clean state, drain rail a past empty and leave the rail b counter full
        c  = CLIENT_W'($urandom_range(7));
        c2 = CLIENT_W'($urandom_range(7));
        for (int i = 0; i < FILL_DEPTH; i++) begin
            send_item(MODE_HOLD_A_ON, c);
            send_item(MODE_HOLD_B_ON, c2);
        end
        for (int i = 0; i < FILL_DEPTH; i++)
            send_item(MODE_REL_A_ON, c);
        c = CLIENT_W'($urandom_range(7));
        for (int i = 0; i < FILL_DEPTH; i++)
            send_item(MODE_HOLD_A_OFF, c);
        for (int i = 0; i < FILL_DEPTH; i++)
            send_item(MODE_REL_A_OFF, c);

        mix_end = items_sent + MIX_ITEMS;
        while (items_sent < mix_end) begin
            sel = $urandom_range(99);
            c   = CLIENT_W'($urandom_range(7));
            if (sel < 30) begin
                send_item(MODE_W'($urandom_range(7)), c);
            end else if (sel < 80) begin
                case ($urandom_range(2))
                    0: begin hold_m = MODE_HOLD_A_ON;  rel_m = MODE_REL_A_ON;  end
                    1: begin hold_m = MODE_HOLD_A_OFF; rel_m = MODE_REL_A_OFF; end
                    default: begin hold_m = MODE_HOLD_B_ON; rel_m = MODE_REL_B_ON; end
                endcase
                reps = $urandom_range(1, 6);
                repeat (reps) send_item(hold_m, c);
                // sometimes one release too many
                repeat (reps + $urandom_range(1)) send_item(rel_m, c);
            end else begin
                hold_m = MODE_W'($urandom_range(5));
                repeat ($urandom_range(1, 10)) send_item(hold_m, c);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS power_rail_hold_arbiter");
        else
            $display("FAIL power_rail_hold_arbiter");
        $finish;
    end

endmodule
